// ===== rtl/core/hkts_pkg.sv =====
`timescale 1ns / 1ps

package hkts_pkg;

  // Entry geometry: eight 32-bit words per entry, word 0 is the sort key.
  localparam int WORD_W          = 32;
  localparam int WORDS_PER_ENTRY = 8;
  localparam int ENTRY_W         = WORD_W * WORDS_PER_ENTRY;
  localparam int BYTES_PER_ENTRY = 32;
  localparam int BYTE_SHIFT      = $clog2(BYTES_PER_ENTRY);

  // Field widths of the stream items and the count register.
  localparam int SLOT_W      = 10;
  localparam int COUNT_REG_W = 11;
  localparam int IN_TDATA_W  = ((SLOT_W + ENTRY_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 32;

  // Default table size and depth of the command queue.
  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [OUT_TDATA_W-1:0] NOT_FOUND_OFFSET = '1;

  // Operation codes carried in s_tuser.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef logic [WORDS_PER_ENTRY-1:0][WORD_W-1:0] entry_t;

  // One classified command handed from the front to the engine.
  typedef struct packed {
    logic               is_search;
    logic [SLOT_W-1:0]  slot;
    entry_t             key;
  } cmd_t;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_PROBE,
    ENG_PROBE_WAIT,
    ENG_SCAN,
    ENG_SCAN_WAIT,
    ENG_RESULT
  } eng_state_t;

endpackage

// ===== rtl/core/hkts_front.sv =====
`timescale 1ns / 1ps

module hkts_front import hkts_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  logic                  s_tuser,
  output logic                  push_valid,
  input  logic                  push_ready,
  output cmd_t                  push_cmd
);

  logic stage_valid;
  logic stage_valid_next;
  cmd_t stage_cmd;
  cmd_t in_cmd;
  logic accept;
  logic keep;

  // Unpack the transfer and decide whether it has any effect.
  always_comb begin
    in_cmd.is_search = (s_tuser == OP_SEARCH);
    in_cmd.slot      = s_tdata[SLOT_W-1:0];
    in_cmd.key       = s_tdata[SLOT_W +: ENTRY_W];
    keep = in_cmd.is_search || (32'(in_cmd.slot) < 32'(TABLE_DEPTH));
  end

  // The stage takes a new transfer whenever it is empty or draining.
  assign s_tready = !stage_valid || push_ready;
  assign accept   = s_tvalid && s_tready;

  // Loads to slots beyond the table are consumed and dropped here.
  always_comb begin
    if (accept) begin
      stage_valid_next = keep;
    end else if (push_ready) begin
      stage_valid_next = 1'b0;
    end else begin
      stage_valid_next = stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_cmd <= in_cmd;
    end
  end

  assign push_valid = stage_valid;
  assign push_cmd   = stage_cmd;

endmodule

// ===== rtl/core/hkts_queue.sv =====
`timescale 1ns / 1ps

module hkts_queue import hkts_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (32'(fill) < 32'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = slots[rd_ptr];

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/core/hkts_engine.sv =====
`timescale 1ns / 1ps

module hkts_engine import hkts_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int CNT_W       = $clog2(DEF_TABLE_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [CNT_W-1:0]       total_count,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  cmd_t                   cmd,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tuser
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  eng_state_t state;
  eng_state_t state_next;

  // Table memory: one row per entry, one write and one registered read.
  entry_t           mem [TABLE_DEPTH];
  entry_t           rd_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;

  entry_t           key;
  logic [CNT_W-1:0] base;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] half;
  logic [CNT_W-1:0] probe_idx;
  logic             probe_lt;
  logic             scan_more;
  logic             word0_eq;
  logic             full_eq;
  logic             res_found;
  logic [OUT_TDATA_W-1:0] res_offset;
  logic             out_load;
  logic             out_valid;

  // Search comparisons.
  always_comb begin
    half      = n >> 1;
    probe_idx = base + half;
    probe_lt  = (rd_data[0] < key[0]);
    scan_more = (base < total_count);
    word0_eq  = (rd_data[0] == key[0]);
    full_eq   = (rd_data == key);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ENG_IDLE: begin
        if (cmd_valid && cmd.is_search) begin
          state_next = ENG_PROBE;
        end
      end
      ENG_PROBE: begin
        state_next = (n == '0) ? ENG_SCAN : ENG_PROBE_WAIT;
      end
      ENG_PROBE_WAIT: begin
        state_next = ENG_PROBE;
      end
      ENG_SCAN: begin
        state_next = scan_more ? ENG_SCAN_WAIT : ENG_RESULT;
      end
      ENG_SCAN_WAIT: begin
        state_next = (!word0_eq || full_eq) ? ENG_RESULT : ENG_SCAN;
      end
      ENG_RESULT: begin
        if (!out_valid || m_tready) begin
          state_next = ENG_IDLE;
        end
      end
      default: begin
        state_next = ENG_IDLE;
      end
    endcase
  end

  // Control outputs per state.
  always_comb begin
    cmd_ready = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = IDX_W'(base);
    out_load  = 1'b0;
    unique case (state)
      ENG_IDLE: begin
        cmd_ready = 1'b1;
        wr_en     = cmd_valid && !cmd.is_search;
      end
      ENG_PROBE: begin
        rd_en   = (n != '0);
        rd_addr = IDX_W'(probe_idx);
      end
      ENG_SCAN: begin
        rd_en = scan_more;
      end
      ENG_RESULT: begin
        out_load = !out_valid || m_tready;
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ENG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Table memory port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[IDX_W'(cmd.slot)] <= cmd.key;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Search datapath: lower-bound bisection, then the forward scan.
  always_ff @(posedge clk) begin
    unique case (state)
      ENG_IDLE: begin
        if (cmd_valid && cmd.is_search) begin
          key        <= cmd.key;
          base       <= '0;
          n          <= total_count;
          res_found  <= 1'b0;
          res_offset <= NOT_FOUND_OFFSET;
        end
      end
      ENG_PROBE_WAIT: begin
        if (probe_lt) begin
          base <= probe_idx + 1'b1;
          n    <= n - half - 1'b1;
        end else begin
          n <= half;
        end
      end
      ENG_SCAN_WAIT: begin
        if (word0_eq && full_eq) begin
          res_found  <= 1'b1;
          res_offset <= OUT_TDATA_W'(base) << BYTE_SHIFT;
        end else if (word0_eq) begin
          base <= base + 1'b1;
        end
      end
      default: begin
        base <= base;
      end
    endcase
  end

  // Result register toward the output stream.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= res_offset;
      m_tuser <= res_found;
    end
  end

  assign m_tvalid = out_valid;

endmodule

// ===== rtl/core/hash_key_table_search_top.sv =====
`timescale 1ns / 1ps
// Loads are written while the engine is idle and can follow back to back. A search holds
// the engine through the bisection probes, the forward-scan reads and the start and result
// states; searches run one at a time. The front stage and the output register add to the
// latency of each result.
// Synchronous active-high reset clears control and entry_count; table contents
// are undefined until loaded.
module hash_key_table_search_top import hkts_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [COUNT_REG_W-1:0] cfg_wr_data,  // entry_count
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,      // entry_index, key_word0..key_word7, zero pad
  input  logic                   s_tuser,      // operation
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,      // byte_offset
  output logic                   m_tuser       // found
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [COUNT_REG_W-1:0] entry_count;
  logic [CNT_W-1:0]       total_count;
  logic                   push_valid;
  logic                   push_ready;
  cmd_t                   push_cmd;
  logic                   pop_valid;
  logic                   pop_ready;
  cmd_t                   pop_cmd;

  // Entry count register, saturated to the table depth for the engine.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wr_en) begin
      entry_count <= cfg_wr_data;
    end
  end

  assign total_count = (32'(entry_count) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                              : CNT_W'(entry_count);

  hkts_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  hkts_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  hkts_engine #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .CNT_W      (CNT_W)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .total_count (total_count),
    .cmd_valid   (pop_valid),
    .cmd_ready   (pop_ready),
    .cmd         (pop_cmd),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule
